### rtl/core/bqlp_pkg.sv
// shared types and constants for the biquad low-pass filter
package bqlp_pkg;

	localparam int COEF_W          = 18;
	localparam int DELAY_W         = 40;
	localparam int NUM_COEFS       = 5;
	localparam int COEF_IDX_W      = 3;
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int COEF_FRAC_DEF   = 16;

	// coefficient register indexes
	typedef enum logic [COEF_IDX_W-1:0] {
		COEF_FF0 = 3'd0,
		COEF_FF1 = 3'd1,
		COEF_FF2 = 3'd2,
		COEF_FB1 = 3'd3,
		COEF_FB2 = 3'd4
	} coef_idx_t;

	localparam logic [COEF_W-1:0] COEF_RESET [NUM_COEFS] = '{
		18'd65536, 18'd0, 18'd0, 18'd0, 18'd0
	};

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_PROD,
		ACC_PROD_D1,
		ACC_PROD_D2,
		ACC_SUB
	} acc_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_FF0,
		ST_ACC_Y,
		ST_ROUND,
		ST_MUL_FB1,
		ST_SUB_FB1,
		ST_WR_D1,
		ST_SUB_FB2,
		ST_WR_D2
	} seq_state_t;

	// datapath controls issued by the sequencer each cycle
	typedef struct packed {
		logic      x_en;
		logic      prod_en;
		coef_idx_t coef_sel;
		logic      use_y;
		acc_op_t   acc_op;
		logic      y_en;
		logic      d1_en;
		logic      d2_en;
	} bqlp_ctrl_t;

endpackage

### rtl/core/biquad_lowpass_filter.sv
// top level of the biquad low-pass filter section
// Second-order IIR section in direct form II transposed.
// Input channel: in_valid / in_ready with sample_in (signed Q1.15 by default).
// Output channel: out_valid / out_ready with sample_out and clipped.
// A beat moves on a channel at a clock edge where its valid and ready are high.
// Configuration: cfg_wr_en writes cfg_data[17:0] into coefficient cfg_index
// (0 ff0, 1 ff1, 2 ff2, 3 fb1, 4 fb2); other indexes are ignored. Write only
// while no sample is in flight.
// Sharing: one 18 x SAMPLE_WIDTH multiplier and one accumulator are shared by
// all five products, so the sequencer steps each sample through its states
// from ST_MUL_FF0 to ST_WR_D2, and a new input beat is taken only once it is
// back in idle. in_ready is high only while the sequencer is idle.
// Stall: a finished result sits in the output register; while it is unread
// the next sample may still be accepted and computed, and the sequencer then
// holds in its last step until out_ready frees the output register.
// Reset (arst_n low): coefficients return to ff0 = 1.0, others 0, both delay
// registers clear, and no result is pending.
module biquad_lowpass_filter import bqlp_pkg::*; #(
	parameter int SAMPLE_WIDTH       = SAMPLE_WIDTH_DEF,
	parameter int COEF_FRACTION_BITS = COEF_FRAC_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_wr_en,
	input  logic [COEF_IDX_W-1:0]          cfg_index,
	input  logic [COEF_W-1:0]              cfg_data,
	// sample input
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	// filtered output
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	output logic                           clipped
);

	logic signed [COEF_W-1:0]       coefs [NUM_COEFS];
	logic signed [SAMPLE_WIDTH-1:0] y;
	logic                           clip;
	logic                           out_load;
	logic                           out_busy;
	bqlp_ctrl_t                     ctrl;

	// result register
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_out_q;
	logic                           clipped_q;

	bqlp_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coefs     (coefs)
	);

	// output register is busy when it holds a result not taken this cycle
	assign out_busy = out_valid_q && !out_ready;

	bqlp_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_busy (out_busy),
		.in_ready (in_ready),
		.out_load (out_load),
		.ctrl     (ctrl)
	);

	bqlp_dp #(
		.SAMPLE_WIDTH       (SAMPLE_WIDTH),
		.COEF_FRACTION_BITS (COEF_FRACTION_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.sample_in (sample_in),
		.coefs     (coefs),
		.y         (y),
		.clip      (clip)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (out_load) begin
			sample_out_q <= y;
			clipped_q    <= clip;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign clipped    = clipped_q;

endmodule

### rtl/core/bqlp_regs.sv
// coefficient register file written through the configuration port
module bqlp_regs import bqlp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [COEF_IDX_W-1:0]    cfg_index,
	input  logic [COEF_W-1:0]        cfg_data,
	output logic signed [COEF_W-1:0] coefs [NUM_COEFS]
);

	logic [COEF_W-1:0] coef_q [NUM_COEFS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFS; i++) begin
				coef_q[i] <= COEF_RESET[i];
			end
		end else if (cfg_wr_en && (cfg_index < COEF_IDX_W'(NUM_COEFS))) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_COEFS; i++) begin
			coefs[i] = $signed(coef_q[i]);
		end
	end

endmodule

### rtl/core/bqlp_seq.sv
// sequencer that steps the shared multiply-accumulate unit through one sample
module bqlp_seq import bqlp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       out_busy,
	output logic       in_ready,
	output logic       out_load,
	output bqlp_ctrl_t ctrl
);

	seq_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		out_load      = 1'b0;
		ctrl.x_en     = 1'b0;
		ctrl.prod_en  = 1'b0;
		ctrl.coef_sel = COEF_FF0;
		ctrl.use_y    = 1'b0;
		ctrl.acc_op   = ACC_HOLD;
		ctrl.y_en     = 1'b0;
		ctrl.d1_en    = 1'b0;
		ctrl.d2_en    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				ctrl.x_en = in_valid;
				if (in_valid) begin
					state_d = ST_MUL_FF0;
				end
			end
			ST_MUL_FF0: begin
				ctrl.prod_en  = 1'b1;
				ctrl.coef_sel = COEF_FF0;
				state_d       = ST_ACC_Y;
			end
			ST_ACC_Y: begin
				ctrl.acc_op   = ACC_PROD_D1;
				ctrl.prod_en  = 1'b1;
				ctrl.coef_sel = COEF_FF1;
				state_d       = ST_ROUND;
			end
			ST_ROUND: begin
				// y taken from the old accumulator while ff1*x + d2 replaces it
				ctrl.y_en   = 1'b1;
				ctrl.acc_op = ACC_PROD_D2;
				state_d     = ST_MUL_FB1;
			end
			ST_MUL_FB1: begin
				ctrl.prod_en  = 1'b1;
				ctrl.coef_sel = COEF_FB1;
				ctrl.use_y    = 1'b1;
				state_d       = ST_SUB_FB1;
			end
			ST_SUB_FB1: begin
				ctrl.acc_op   = ACC_SUB;
				ctrl.prod_en  = 1'b1;
				ctrl.coef_sel = COEF_FF2;
				state_d       = ST_WR_D1;
			end
			ST_WR_D1: begin
				ctrl.d1_en    = 1'b1;
				ctrl.acc_op   = ACC_PROD;
				ctrl.prod_en  = 1'b1;
				ctrl.coef_sel = COEF_FB2;
				ctrl.use_y    = 1'b1;
				state_d       = ST_SUB_FB2;
			end
			ST_SUB_FB2: begin
				ctrl.acc_op = ACC_SUB;
				state_d     = ST_WR_D2;
			end
			ST_WR_D2: begin
				// wait here while the previous result is still unread
				if (!out_busy) begin
					ctrl.d2_en = 1'b1;
					out_load   = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/bqlp_dp.sv
// shared multiplier, accumulator, rounding and delay registers
module bqlp_dp import bqlp_pkg::*; #(
	parameter int SAMPLE_WIDTH       = SAMPLE_WIDTH_DEF,
	parameter int COEF_FRACTION_BITS = COEF_FRAC_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bqlp_ctrl_t                     ctrl,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  logic signed [COEF_W-1:0]       coefs [NUM_COEFS],
	output logic signed [SAMPLE_WIDTH-1:0] y,
	output logic                           clip
);

	localparam int PROD_W = COEF_W + SAMPLE_WIDTH;
	localparam int ACC_A  = (DELAY_W > PROD_W) ? DELAY_W + 3 : PROD_W + 3;
	localparam int ACC_B  = SAMPLE_WIDTH + COEF_FRACTION_BITS + 1;
	localparam int ACC_W  = (ACC_A > ACC_B) ? ACC_A : ACC_B;
	localparam int R_W    = ACC_W - COEF_FRACTION_BITS;
	localparam logic [ACC_W-1:0] ROUND_HALF =
		{{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRACTION_BITS - 1);

	logic signed [SAMPLE_WIDTH-1:0] x_q, y_q, mul_b, y_d;
	logic signed [COEF_W-1:0]       mul_a;
	logic signed [PROD_W-1:0]       prod, prod_q;
	logic signed [ACC_W-1:0]        acc_q, acc_d, prod_ext, d1_ext, d2_ext;
	logic [ACC_W-1:0]               rnd;
	logic [R_W-1:0]                 r;
	logic signed [DELAY_W-1:0]      d1_q, d2_q, dsat;
	logic                           clip_q, clip_d, r_fits, d_fits;

	always_comb begin
		unique case (ctrl.coef_sel)
			COEF_FF0: mul_a = coefs[0];
			COEF_FF1: mul_a = coefs[1];
			COEF_FF2: mul_a = coefs[2];
			COEF_FB1: mul_a = coefs[3];
			COEF_FB2: mul_a = coefs[4];
			default:  mul_a = coefs[0];
		endcase
	end

	assign mul_b    = ctrl.use_y ? y_q : x_q;
	assign prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign prod_ext = ACC_W'(prod_q);
	assign d1_ext   = ACC_W'(d1_q);
	assign d2_ext   = ACC_W'(d2_q);

	always_comb begin
		unique case (ctrl.acc_op)
			ACC_HOLD:    acc_d = acc_q;
			ACC_PROD:    acc_d = prod_ext;
			ACC_PROD_D1: acc_d = prod_ext + d1_ext;
			ACC_PROD_D2: acc_d = prod_ext + d2_ext;
			ACC_SUB:     acc_d = acc_q - prod_ext;
			default:     acc_d = acc_q;
		endcase
	end

	// round half up, then saturate to the sample range
	assign rnd    = acc_q + ROUND_HALF;
	assign r      = rnd[ACC_W-1:COEF_FRACTION_BITS];
	assign r_fits = (&r[R_W-1:SAMPLE_WIDTH-1]) || !(|r[R_W-1:SAMPLE_WIDTH-1]);
	assign clip_d = !r_fits;
	assign y_d    = r_fits ? $signed(r[SAMPLE_WIDTH-1:0]) :
		(r[R_W-1] ? $signed({1'b1, {(SAMPLE_WIDTH-1){1'b0}}}) :
		            $signed({1'b0, {(SAMPLE_WIDTH-1){1'b1}}}));

	// clamp of the accumulator into the delay range
	assign d_fits = (&acc_q[ACC_W-1:DELAY_W-1]) || !(|acc_q[ACC_W-1:DELAY_W-1]);
	assign dsat   = d_fits ? acc_q[DELAY_W-1:0] :
		(acc_q[ACC_W-1] ? $signed({1'b1, {(DELAY_W-1){1'b0}}}) :
		                  $signed({1'b0, {(DELAY_W-1){1'b1}}}));

	always_ff @(posedge clk) begin
		if (ctrl.x_en) begin
			x_q <= sample_in;
		end
		if (ctrl.prod_en) begin
			prod_q <= prod;
		end
		acc_q <= acc_d;
		if (ctrl.y_en) begin
			y_q    <= y_d;
			clip_q <= clip_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
		end else begin
			if (ctrl.d1_en) begin
				d1_q <= dsat;
			end
			if (ctrl.d2_en) begin
				d2_q <= dsat;
			end
		end
	end

	assign y    = y_q;
	assign clip = clip_q;

endmodule

### dv/bqlp_checker.sv
// scoreboard for the biquad low-pass filter: predicts every output beat and compares it
`timescale 1ns / 1ps
module bqlp_checker import bqlp_pkg::*; #(
	parameter int SAMPLE_WIDTH       = SAMPLE_WIDTH_DEF,
	parameter int COEF_FRACTION_BITS = COEF_FRAC_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [COEF_IDX_W-1:0]          cfg_index,
	input  logic [COEF_W-1:0]              cfg_data,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_out,
	input  logic                           clipped,
	output int                             fail_count,
	output int                             pending
);

	typedef struct {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           clip;
	} filt_out_t;

	localparam longint SMP_MAX   = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
	localparam longint SMP_MIN   = -SMP_MAX - 64'sd1;
	localparam longint DLY_MAX   = (64'sd1 <<< (DELAY_W - 1)) - 64'sd1;
	localparam longint DLY_MIN   = -DLY_MAX - 64'sd1;
	localparam longint ROUND_BIAS = 64'sd1 <<< (COEF_FRACTION_BITS - 1);

	logic signed [COEF_W-1:0]  coef_r [NUM_COEFS];
	logic signed [DELAY_W-1:0] dly1;
	logic signed [DELAY_W-1:0] dly2;
	filt_out_t                 expected_q [$];
	filt_out_t                 want;
	int                        fails;

	function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// one sample through the transposed section, updating both delays
	function filt_out_t biquad_step(input logic signed [SAMPLE_WIDTH-1:0] x);
		longint    xs;
		longint    acc;
		longint    rounded;
		longint    y;
		longint    nxt1;
		longint    nxt2;
		filt_out_t res;
		xs      = x;
		acc     = longint'(coef_r[COEF_FF0]) * xs + longint'(dly1);
		rounded = (acc + ROUND_BIAS) >>> COEF_FRACTION_BITS;
		y       = clamp_to(rounded, SMP_MIN, SMP_MAX);
		nxt1    = longint'(coef_r[COEF_FF1]) * xs - longint'(coef_r[COEF_FB1]) * y
			+ longint'(dly2);
		nxt2    = longint'(coef_r[COEF_FF2]) * xs - longint'(coef_r[COEF_FB2]) * y;
		dly1    = DELAY_W'(clamp_to(nxt1, DLY_MIN, DLY_MAX));
		dly2    = DELAY_W'(clamp_to(nxt2, DLY_MIN, DLY_MAX));
		res.sample = y[SAMPLE_WIDTH-1:0];
		res.clip   = (y != rounded);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFS; i++)
				coef_r[i] = COEF_RESET[i];
			dly1 = '0;
			dly2 = '0;
			expected_q.delete();
			fails = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected output beat: sample_out %0d clipped %0b",
							sample_out, clipped);
				end else begin
					want = expected_q.pop_front();
					if (sample_out !== want.sample || clipped !== want.clip) begin
						fails++;
						if (fails <= 10)
							$display("mismatch: sample_out exp %0d got %0d, clipped exp %0b got %0b",
								want.sample, sample_out, want.clip, clipped);
					end
				end
			end
			// writes to indexes past the last coefficient are dropped
			if (cfg_wr_en && cfg_index < NUM_COEFS)
				coef_r[cfg_index] = cfg_data;
			if (in_valid && in_ready)
				expected_q.push_back(biquad_step(sample_in));
			fail_count <= fails;
			pending <= expected_q.size();
		end
	end

endmodule

### dv/tb_top.sv
// testbench top for the biquad low-pass filter: stimulus, pacing and verdict
`timescale 1ns / 1ps
module tb_top;
	import bqlp_pkg::*;

	localparam int SW         = SAMPLE_WIDTH_DEF;
	localparam int SETTLE_CYC = 12;
	localparam int HOLD_CYC   = 80;    // long receiver hold-off, fills the block
	localparam int STALL_MAX  = 4000;  // cycles without any beat before giving up
	localparam int NUM_PHASES = 16;
	localparam int PHASE_LEN  = 27;

	localparam logic signed [SW-1:0]     SMP_MAX  = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0]     SMP_MIN  = {1'b1, {(SW-1){1'b0}}};
	localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [COEF_IDX_W-1:0]  cfg_index;
	logic [COEF_W-1:0]      cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic signed [SW-1:0]   sample_in;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic signed [SW-1:0]   sample_out;
	logic                   clipped;

	int                     fail_count;
	int                     pending;

	// pacing knobs, percent of cycles spent idle on each side
	int                     tx_idle_pct = 0;
	int                     rx_idle_pct = 0;
	logic                   hold_req    = 1'b0;
	logic                   hold_taken  = 1'b0;
	int                     hold_left   = 0;
	int                     stall_cnt   = 0;

	// coefficient set staged for the next load, in register order
	logic signed [COEF_W-1:0] cset [NUM_COEFS];
	logic signed [SW-1:0]     last_x = '0;

	biquad_lowpass_filter u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.clipped    (clipped)
	);

	bqlp_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.clipped    (clipped),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver: random ready, plus one long hold-off on request so that the
	// output register stays full and the block backs up into its input
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= HOLD_CYC;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// watchdog: any beat on either channel restarts the count
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_MAX) begin
			$display("watchdog: no beat for %0d cycles", STALL_MAX);
			$display("Simulation FAILED");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	// offer one sample, with random idle cycles ahead of it, and hold it until taken
	task automatic push_sample(input logic signed [SW-1:0] x);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= x;
		last_x = x;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// drain: every result back (the delay updates are done by then), then a further idle wait;
	// wait on the clock first so the count already holds the last accepted beat
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [COEF_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// write the staged set; optionally a junk write to an unused index that must not land
	task automatic load_coefs(input bit with_spare);
		write_reg(COEF_FF0, cset[COEF_FF0]);
		write_reg(COEF_FF1, cset[COEF_FF1]);
		write_reg(COEF_FF2, cset[COEF_FF2]);
		write_reg(COEF_FB1, cset[COEF_FB1]);
		write_reg(COEF_FB2, cset[COEF_FB2]);
		if (with_spare)
			write_reg(COEF_IDX_W'($urandom_range(2**COEF_IDX_W - 1, NUM_COEFS)),
				COEF_W'($urandom));
		cfg_wr_en <= 1'b0;
	endtask

	// mix of full-scale noise, quiet signal, rail hits and held values
	function automatic logic signed [SW-1:0] pick_sample();
		case ($urandom_range(3))
			0: return SW'($urandom);
			1: return SW'(int'($urandom_range(2000)) - 1000);
			2: return $urandom_range(1) ? SMP_MAX : SMP_MIN;
			default: return last_x;
		endcase
	endfunction

	// coefficient pick: a stable low-pass design with jitter, raw random, or rails and zero
	task automatic stage_coefs(input int kind);
		case (kind)
			0: begin
				case ($urandom_range(2))
					0: cset = '{18'sd1316, 18'sd2632, 18'sd1316, -18'sd102302, 18'sd42032};
					1: cset = '{18'sd4421, 18'sd8842, 18'sd4421, -18'sd74906, 18'sd27054};
					default: cset = '{18'sd19195, 18'sd38390, 18'sd19195, 18'sd0, 18'sd11244};
				endcase
				for (int i = 0; i < NUM_COEFS; i++)
					cset[i] = COEF_W'(int'(cset[i]) + int'($urandom_range(63)) - 32);
			end
			1: begin
				for (int i = 0; i < NUM_COEFS; i++)
					cset[i] = COEF_W'($urandom);
			end
			default: begin
				for (int i = 0; i < NUM_COEFS; i++)
					case ($urandom_range(2))
						0: cset[i] = COEF_MAX;
						1: cset[i] = COEF_MIN;
						default: cset[i] = '0;
					endcase
			end
		endcase
	endtask

	initial begin
		in_valid <= 1'b0;
		sample_in <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= COEF_FF0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset coefficients give unity gain: rails, zero and small values pass through
		push_sample('0);
		push_sample(SMP_MAX);
		push_sample(SMP_MIN);
		push_sample(SW'(1));
		push_sample(-SW'(1));
		push_sample(SW'(16'h5555));
		push_sample(SW'(16'haaaa));

		// tiny gain puts the accumulator exactly on the half and just past it, both signs
		settle();
		cset = '{18'sd2, 18'sd0, 18'sd0, 18'sd0, 18'sd0};
		load_coefs(1'b1);
		push_sample(SW'(16384));
		push_sample(-SW'(16384));
		push_sample(SW'(16385));
		push_sample(-SW'(16385));

		// rail coefficients: output clips both ways, feedback runs at full swing
		settle();
		cset = '{COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX};
		load_coefs(1'b0);
		push_sample(SMP_MAX);
		push_sample(SMP_MIN);
		push_sample(SMP_MAX);
		push_sample(SMP_MIN);
		push_sample('0);
		push_sample('0);

		// most negative coefficient times most negative sample
		settle();
		cset = '{COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN};
		load_coefs(1'b0);
		push_sample(SMP_MIN);
		push_sample(SMP_MAX);
		push_sample(SW'(100));
		push_sample('0);

		// random phases: sender mostly busy first, then receiver mostly busy, then both never idle
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			settle();
			if (ph < 6) begin
				tx_idle_pct = 18;
				rx_idle_pct <= 80;
			end else if (ph < 12) begin
				tx_idle_pct = 80;
				rx_idle_pct <= 18;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct <= 0;
			end
			stage_coefs(ph % 3);
			load_coefs(bit'($urandom_range(1)));
			// sender keeps offering at full rate while the receiver holds off
			if (ph == 13)
				hold_req <= 1'b1;
			for (int n = 0; n < PHASE_LEN; n++)
				push_sample(pick_sample());
		end

		settle();
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### sim.f
rtl/core/bqlp_pkg.sv
rtl/core/bqlp_regs.sv
rtl/core/bqlp_seq.sv
rtl/core/bqlp_dp.sv
rtl/core/biquad_lowpass_filter.sv
dv/bqlp_checker.sv
dv/tb_top.sv
